@@ src/fmbw_pkg.sv @@
// Shared types, constants and scoring functions for the fuzzy best-word matcher.
// No dependencies; every other file in src but fmbw_ram uses it by scoped names.
`default_nettype none

package fmbw_pkg;

  // Query store and field widths
  localparam int QUERY_LEN  = 128;
  localparam int QADDR_W    = $clog2(QUERY_LEN);
  localparam int QLEN_W     = $clog2(QUERY_LEN + 1);
  localparam int WORD_LEN   = 255;
  localparam int WLEN_W     = $clog2(WORD_LEN + 1);
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 10;
  localparam int PTS_W      = 12;
  localparam int TALLY_W    = 5;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  // Score constants, one bit wider than the running score for headroom
  localparam logic signed [PTS_W:0] PTS_LO    = (PTS_W + 1)'(-512);
  localparam logic signed [PTS_W:0] PTS_HI    = (PTS_W + 1)'(2047);
  localparam logic signed [PTS_W:0] BONUS_SEP = (PTS_W + 1)'(10);
  localparam logic signed [PTS_W:0] BONUS_RUN = (PTS_W + 1)'(5);
  localparam logic signed [PTS_W:0] MISS_COST = (PTS_W + 1)'(-1);

  localparam logic signed [TALLY_W:0] TALLY_STEP = (TALLY_W + 1)'(3);
  localparam logic signed [TALLY_W:0] TALLY_LO   = (TALLY_W + 1)'(-9);

  localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;
  localparam logic [CHAR_W-1:0] SPACE_CH  = 8'd32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_WORD = 1'b1
  } op_t;

  // One input beat
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic              first;
    logic              eow;
    logic              eol;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [CNT_W-1:0]        word_number;
    logic signed [PTS_W-1:0] word_points;
    logic                    list_done;
    logic                    best_found;
    logic [CNT_W-1:0]        best_number;
    logic signed [PTS_W-1:0] best_points;
  } result_t;

  // Per-word scoring state
  typedef struct packed {
    logic                      run;
    logic signed [PTS_W-1:0]   pts;
    logic signed [TALLY_W-1:0] tally;
  } score_t;

  typedef struct packed {
    logic   hit;
    score_t s;
  } score_res_t;

  // Control bytes, space and the upper half count as separators
  function automatic logic is_sep(input logic [CHAR_W-1:0] b);
    return b[CHAR_W-1] || (b <= SPACE_CH);
  endfunction

  function automatic logic signed [PTS_W-1:0] clamp_pts(input logic signed [PTS_W:0] v);
    logic signed [PTS_W-1:0] r;
    if (v < PTS_LO) begin
      r = PTS_LO[PTS_W-1:0];
    end else if (v > PTS_HI) begin
      r = PTS_HI[PTS_W-1:0];
    end else begin
      r = v[PTS_W-1:0];
    end
    return r;
  endfunction

  // Score byte c (previous p, next n) against query byte q
  function automatic score_res_t score_byte(
    input logic [CHAR_W-1:0] c,
    input logic [CHAR_W-1:0] p,
    input logic [CHAR_W-1:0] n,
    input logic [CHAR_W-1:0] q,
    input logic              active,
    input score_t            s
  );
    score_res_t               r;
    logic                     leading;
    logic signed [PTS_W:0]    step;
    logic signed [PTS_W:0]    ext;
    logic signed [TALLY_W:0]  t;
    r       = '0;
    r.s     = s;
    leading = c[6] && !n[6];
    ext     = (PTS_W + 1)'(s.pts);
    t       = (TALLY_W + 1)'(s.tally);
    step    = MISS_COST;
    if (active) begin
      if ((c & CASE_MASK) == (q & CASE_MASK)) begin
        r.hit   = 1'b1;
        r.s.run = 1'b1;
        if (is_sep(p) || leading) begin
          step = BONUS_SEP;
        end else if (s.run) begin
          step = BONUS_RUN;
        end else begin
          step = '0;
        end
      end else begin
        r.s.run = 1'b0;
        if (leading) begin
          t = t - TALLY_STEP;
          if (t < TALLY_LO) begin
            t = TALLY_LO;
          end
          r.s.tally = t[TALLY_W-1:0];
        end
      end
      r.s.pts = clamp_pts(ext + step);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/fmbw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fmbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ src/fmbw_core.sv @@
// Scoring core: query store, per-word scoring state and best-word tracking.
// Depends on fmbw_pkg and fmbw_ram.
`default_nettype none

module fmbw_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire fmbw_pkg::item_t  item,
  output logic                  res_v,
  output fmbw_pkg::result_t     res
);

  localparam int AW = fmbw_pkg::QADDR_W;

  // query store control
  logic [fmbw_pkg::QLEN_W-1:0] qlen_r,  qlen_nxt;
  logic [fmbw_pkg::QLEN_W-1:0] cur_r,   cur_nxt;
  logic [fmbw_pkg::CHAR_W-1:0] qcur_r,  qcur_nxt;  // query byte at cursor
  logic [fmbw_pkg::CHAR_W-1:0] q0_r,    q0_nxt;    // query byte 0
  logic                        byp_v_r, byp_v_nxt;
  logic [fmbw_pkg::CHAR_W-1:0] byp_d_r, byp_d_nxt;

  // word state
  logic [fmbw_pkg::CHAR_W-1:0] held_r, held_nxt;
  logic [fmbw_pkg::CHAR_W-1:0] bef_r,  bef_nxt;
  fmbw_pkg::score_t            sc_r,   sc_nxt;
  logic [fmbw_pkg::WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [fmbw_pkg::CNT_W-1:0]  wcnt_r, wcnt_nxt;

  // best word so far
  logic signed [fmbw_pkg::PTS_W-1:0] top_pts_r, top_pts_nxt;
  logic [fmbw_pkg::CNT_W-1:0]        top_num_r, top_num_nxt;
  logic [fmbw_pkg::WLEN_W-1:0]       top_len_r, top_len_nxt;
  logic                              top_v_r,   top_v_nxt;

  // RAM port
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic [fmbw_pkg::CHAR_W-1:0] ram_q;

  // combinational intermediates
  logic [fmbw_pkg::QLEN_W-1:0]       eff;
  logic [fmbw_pkg::CHAR_W-1:0]       rd_q;
  logic                              new_w;
  fmbw_pkg::score_res_t              r1, r2;
  logic [fmbw_pkg::QLEN_W-1:0]       cur1;
  logic [fmbw_pkg::CHAR_W-1:0]       q1;
  fmbw_pkg::score_t                  sa;
  logic [fmbw_pkg::CHAR_W-1:0]       pb;
  logic [fmbw_pkg::WLEN_W-1:0]       wlen1;
  logic signed [fmbw_pkg::PTS_W:0]   pts_x, tly_x;
  logic signed [fmbw_pkg::PTS_W-1:0] wpts;
  logic                              ge, keep;
  logic signed [fmbw_pkg::PTS_W-1:0] tpts_new;
  logic [fmbw_pkg::CNT_W-1:0]        tnum_new;
  logic [fmbw_pkg::WLEN_W-1:0]       tlen_new;
  logic                              tv_new;

  fmbw_ram #(
    .WIDTH (fmbw_pkg::CHAR_W),
    .DEPTH (fmbw_pkg::QUERY_LEN)
  ) u_qram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (item.ch),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // scoring datapath: held byte first, then the final byte at word end
  always_comb begin
    eff  = item.first ? '0 : qlen_r;
    rd_q = byp_v_r ? byp_d_r : ram_q;   // query byte at cursor + 1
    new_w = item.first || (wlen_r == '0);

    r1 = fmbw_pkg::score_byte(held_r, bef_r, item.ch, qcur_r,
                              (cur_r < qlen_r) && !new_w, sc_r);
    if (new_w) begin
      cur1  = '0;
      q1    = q0_r;
      sa    = '0;
      pb    = '0;
      wlen1 = fmbw_pkg::WLEN_W'(1);
    end else begin
      cur1  = r1.hit ? cur_r + fmbw_pkg::QLEN_W'(1) : cur_r;
      q1    = r1.hit ? rd_q : qcur_r;
      sa    = r1.s;
      pb    = held_r;
      wlen1 = (wlen_r < fmbw_pkg::WLEN_W'(fmbw_pkg::WORD_LEN)) ?
              wlen_r + fmbw_pkg::WLEN_W'(1) : wlen_r;
    end

    r2 = fmbw_pkg::score_byte(item.ch, pb, '0, q1, cur1 < qlen_r, sa);

    // word score and best-word update
    pts_x = (fmbw_pkg::PTS_W + 1)'(r2.s.pts);
    tly_x = (fmbw_pkg::PTS_W + 1)'(r2.s.tally);
    wpts  = fmbw_pkg::clamp_pts(pts_x + tly_x);
    ge    = wpts >= top_pts_r;
    keep  = (wpts == top_pts_r) && top_v_r && (top_len_r < wlen1);
    tpts_new = ge ? wpts : top_pts_r;
    tnum_new = (ge && !keep) ? wcnt_r : top_num_r;
    tlen_new = (ge && !keep) ? wlen1 : top_len_r;
    tv_new   = ge || top_v_r;
  end

  // next state
  always_comb begin
    qlen_nxt    = qlen_r;
    cur_nxt     = cur_r;
    qcur_nxt    = qcur_r;
    q0_nxt      = q0_r;
    held_nxt    = held_r;
    bef_nxt     = bef_r;
    sc_nxt      = sc_r;
    wlen_nxt    = wlen_r;
    wcnt_nxt    = wcnt_r;
    top_pts_nxt = top_pts_r;
    top_num_nxt = top_num_r;
    top_len_nxt = top_len_r;
    top_v_nxt   = top_v_r;
    wr_en       = 1'b0;
    wr_addr     = eff[AW-1:0];
    res_v       = 1'b0;
    res         = '0;

    if (go) begin
      case (item.op)
        fmbw_pkg::OP_LOAD: begin
          qlen_nxt = eff;
          if (eff < fmbw_pkg::QLEN_W'(fmbw_pkg::QUERY_LEN)) begin
            wr_en    = 1'b1;
            qlen_nxt = eff + fmbw_pkg::QLEN_W'(1);
            if (eff == '0) begin
              q0_nxt = item.ch;
            end
            if (eff == cur_r) begin
              qcur_nxt = item.ch;
            end
          end
        end
        fmbw_pkg::OP_WORD: begin
          if (item.eow) begin
            res_v            = 1'b1;
            res.word_number  = wcnt_r;
            res.word_points  = wpts;
            res.list_done    = item.eol;
            res.best_found   = item.eol && tv_new;
            res.best_number  = (item.eol && tv_new) ? tnum_new : '0;
            res.best_points  = item.eol ? tpts_new : '0;
            if (item.eol) begin
              wcnt_nxt    = '0;
              top_pts_nxt = '0;
              top_num_nxt = '0;
              top_len_nxt = '0;
              top_v_nxt   = 1'b0;
            end else begin
              wcnt_nxt    = wcnt_r + fmbw_pkg::CNT_W'(1);
              top_pts_nxt = tpts_new;
              top_num_nxt = tnum_new;
              top_len_nxt = tlen_new;
              top_v_nxt   = tv_new;
            end
            cur_nxt  = '0;
            qcur_nxt = q0_r;
            held_nxt = '0;
            bef_nxt  = '0;
            sc_nxt   = '0;
            wlen_nxt = '0;
          end else begin
            cur_nxt  = cur1;
            qcur_nxt = q1;
            held_nxt = item.ch;
            bef_nxt  = pb;
            sc_nxt   = sa;
            wlen_nxt = wlen1;
          end
        end
        default: ;
      endcase
    end

    // look one query byte ahead; forward a write to the same entry
    rd_addr   = AW'(cur_nxt + fmbw_pkg::QLEN_W'(1));
    byp_v_nxt = wr_en && (wr_addr == rd_addr);
    byp_d_nxt = item.ch;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r    <= '0;
      cur_r     <= '0;
      byp_v_r   <= 1'b0;
      held_r    <= '0;
      bef_r     <= '0;
      sc_r      <= '0;
      wlen_r    <= '0;
      wcnt_r    <= '0;
      top_pts_r <= '0;
      top_num_r <= '0;
      top_len_r <= '0;
      top_v_r   <= 1'b0;
    end else begin
      qlen_r    <= qlen_nxt;
      cur_r     <= cur_nxt;
      byp_v_r   <= byp_v_nxt;
      held_r    <= held_nxt;
      bef_r     <= bef_nxt;
      sc_r      <= sc_nxt;
      wlen_r    <= wlen_nxt;
      wcnt_r    <= wcnt_nxt;
      top_pts_r <= top_pts_nxt;
      top_num_r <= top_num_nxt;
      top_len_r <= top_len_nxt;
      top_v_r   <= top_v_nxt;
    end
  end

  // cached query bytes
  always_ff @(posedge clk) begin
    qcur_r  <= qcur_nxt;
    q0_r    <= q0_nxt;
    byp_d_r <= byp_d_nxt;
  end

endmodule

`default_nettype wire

@@ src/fmbw_outbuf.sv @@
// Result register with a skid stage so the core keeps running while a beat waits.
// Depends on fmbw_pkg.
`default_nettype none

module fmbw_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_v,
  input  wire fmbw_pkg::result_t  res,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output fmbw_pkg::result_t       out_res,
  output logic                    full
);

  logic              out_v_r, out_v_nxt;
  fmbw_pkg::result_t out_d_r, out_d_nxt;
  logic              sk_v_r,  sk_v_nxt;
  fmbw_pkg::result_t sk_d_r,  sk_d_nxt;

  // the core only produces when the skid slot is empty
  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    if (out_v_r && !out_tready) begin
      if (res_v) begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = res;
      end
    end else if (sk_v_r) begin
      out_v_nxt = 1'b1;
      out_d_nxt = sk_d_r;
      sk_v_nxt  = 1'b0;
    end else begin
      out_v_nxt = res_v;
      out_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_res    = out_d_r;
  assign full       = sk_v_r;

endmodule

`default_nettype wire

@@ src/fuzzy_match_best_word.sv @@
// Top level of the fuzzy best-word matcher: input register, scoring core, result buffer.
// Depends on fmbw_pkg, fmbw_core, fmbw_outbuf (and fmbw_ram through the core).
//
//   channel | direction | carries
//   --------+-----------+------------------------------------------------
//   in_     | slave     | query load beats and candidate word bytes
//   out_    | master    | one beat per finished word, best word at list end
//
// Throughput is one beat per clock while the output is not backed up; a word's last byte
// passes the input register, then its result is held in the result register.
// The query byte compare reads a 128-entry store one entry ahead of the cursor.
// Reset clears all control state at once; no clearing pass. Query entries are
// undefined until loaded.
// Input stalls only when both the result register and its skid stage are full.
`default_nettype none

module fuzzy_match_best_word (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in: tdata = char_code; tuser = {last_of_list, first, opcode}; tlast = last_of_word
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [fmbw_pkg::CHAR_W-1:0]        in_tdata,   // [7:0] char_code
  input  wire logic [fmbw_pkg::IN_USER_W-1:0]     in_tuser,   // [0] opcode [1] first [2] last_of_list
  input  wire logic                               in_tlast,
  // out: tlast = list_done, tuser = best_found
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [fmbw_pkg::OUT_DATA_W-1:0]         out_tdata,  // [9:0] word_number [21:10] word_points
                                                              // [31:22] best_number [43:32] best_points
  output logic                                    out_tuser,  // [0] best_found
  output logic                                    out_tlast
);

  logic              v1_r, v1_nxt;
  fmbw_pkg::item_t   item_r, item_nxt;
  logic              go;
  logic              res_v;
  fmbw_pkg::result_t res;
  fmbw_pkg::result_t out_res;
  logic              ob_full;

  // input register
  assign go        = v1_r && !ob_full;
  assign in_tready = !v1_r || !ob_full;

  always_comb begin
    v1_nxt   = v1_r;
    item_nxt = item_r;
    if (in_tvalid && in_tready) begin
      v1_nxt         = 1'b1;
      item_nxt.op    = fmbw_pkg::op_t'(in_tuser[0]);
      item_nxt.ch    = in_tdata;
      item_nxt.first = in_tuser[1];
      item_nxt.eow   = in_tlast;
      item_nxt.eol   = in_tuser[2];
    end else if (go) begin
      v1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  fmbw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .res_v (res_v),
    .res   (res)
  );

  fmbw_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_v      (res_v),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res),
    .full       (ob_full)
  );

  // result beat packing
  assign out_tdata = fmbw_pkg::OUT_DATA_W'({out_res.best_points, out_res.best_number,
                                            out_res.word_points, out_res.word_number});
  assign out_tlast = out_res.list_done;
  assign out_tuser = out_res.best_found;

endmodule

`default_nettype wire

@@ src/fmbw_chk.sv @@
// Port-level checks for the fuzzy best-word matcher, bound to its top level.
// Depends on fmbw_pkg and fuzzy_match_best_word.
`default_nettype none

module fmbw_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [fmbw_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                             out_tuser,
  input wire logic                             out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // best found flag and best points are zero on a beat that does not end the list
  a_best_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser && (out_tdata[43:32] == '0))
    else $error("best fields set before list end");

  // best number is zero when no best word was found
  a_num_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:22] == '0)
    else $error("best number set without a best word");

  // input only stalls when results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind fuzzy_match_best_word fmbw_chk u_fmbw_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
